// File: rtl/chtm_pkg.sv
// Shared types and constants for the channel hit time merger.
package chtm_pkg;

  localparam int unsigned TimeW   = 20;
  localparam int unsigned EnergyW = 24;
  localparam int unsigned PartW   = 8;
  localparam int unsigned TrackW  = 16;
  localparam int unsigned PadW    = 4;
  localparam int unsigned StatW   = 3;
  localparam int unsigned EntryW  = TimeW + EnergyW + PartW + TrackW;
  localparam int unsigned NumW    = TimeW + EnergyW + 1;
  localparam int unsigned DenW    = EnergyW + 1;

  localparam logic [StatW-1:0] StNew      = 3'd0;
  localparam logic [StatW-1:0] StMerged   = 3'd1;
  localparam logic [StatW-1:0] StFull     = 3'd2;
  localparam logic [StatW-1:0] StIgnored  = 3'd3;
  localparam logic [StatW-1:0] StReadHit  = 3'd4;
  localparam logic [StatW-1:0] StReadNone = 3'd5;

  localparam logic OpDeposit = 1'b0;
  localparam logic OpReadout = 1'b1;

  localparam logic [0:0] CfgWindow    = 1'b0;
  localparam logic [0:0] CfgThreshold = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SREQ, S_SCHK, S_MUL1, S_MUL2, S_DIV, S_MWR,
    S_NEWWR, S_EMIT, S_RREQ, S_RCHK, S_REMIT, S_RDONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_idx;
    logic inc_idx;
    logic rd_slot;
    logic mul1;
    logic mul2;
    logic div_start;
    logic wr_merge;
    logic wr_new;
    logic clr_count;
    logic set_res;
    logic [StatW-1:0] res_status;
    logic res_zero;
    logic res_echo;
    logic res_last;
    logic res_hold;
    logic mark_last;
    logic flush_pending;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic ignore;
    logic pad_bad;
    logic idx_end;
    logic full;
    logic hit_match;
    logic over_thr;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/chtm_ram.sv
// Generic single port RAM with registered read.
module chtm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/chtm_div.sv
// Restoring serial divider, one quotient bit per cycle.
module chtm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [chtm_pkg::NumW-1:0] num_i,
  input  logic [chtm_pkg::DenW-1:0] den_i,
  output logic                      done_o,
  output logic [chtm_pkg::NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(chtm_pkg::NumW + 1);
  logic [chtm_pkg::NumW-1:0] quo_q;
  logic [chtm_pkg::DenW:0]   rem_q;
  logic [chtm_pkg::DenW-1:0] den_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic [chtm_pkg::DenW:0]   shl;
  logic [chtm_pkg::DenW:0]   diff;

  assign shl  = {rem_q[chtm_pkg::DenW-1:0], quo_q[chtm_pkg::NumW-1]};
  assign diff = shl - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(chtm_pkg::NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[chtm_pkg::DenW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[chtm_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_q <= shl;
        quo_q <= {quo_q[chtm_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o  = quo_q;
endmodule

// File: rtl/chtm_datapath.sv
// Datapath: hit tables, counts, weighted time arithmetic and result register.
module chtm_datapath #(
  parameter int unsigned HitSlots = 32,
  parameter int unsigned Paddles  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chtm_pkg::ctrl_t        ctrl_i,
  output chtm_pkg::stat_t        stat_o,
  input  logic [72:0]            in_data_i,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [23:0]            cfg_data_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [71:0]            m_tdata_o,
  output logic [2:0]             m_tuser_o,
  output logic                   m_tlast_o
);
  localparam int unsigned SlotW = (HitSlots > 1) ? $clog2(HitSlots) : 1;
  localparam int unsigned CntW  = $clog2(HitSlots + 1);
  localparam int unsigned PIdxW = (Paddles > 1) ? $clog2(Paddles) : 1;
  localparam int unsigned Depth = Paddles * HitSlots;
  localparam int unsigned AddrW = $clog2(Depth) > 0 ? $clog2(Depth) : 1;
  localparam int unsigned TW = chtm_pkg::TimeW;
  localparam int unsigned EW = chtm_pkg::EnergyW;

  logic [15:0] win_q;
  logic [EW-1:0] thr_q;
  logic op_q;
  logic [chtm_pkg::PadW-1:0] pad_q;
  logic [TW-1:0] t_q;
  logic [EW-1:0] e_q;
  logic [7:0] pt_q;
  logic [15:0] tr_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] cnt_q [Paddles];
  logic [CntW-1:0] n_cur;
  logic [PIdxW-1:0] pidx;
  logic pad_ok;
  logic [AddrW-1:0] addr;
  logic we;
  logic [chtm_pkg::EntryW-1:0] wdata, rdata;
  logic [TW-1:0] rt;
  logic [EW-1:0] re;
  logic [7:0] rp;
  logic [15:0] rtr;
  logic [TW:0] tdiff;
  logic [chtm_pkg::NumW-1:0] acc_q;
  logic [chtm_pkg::DenW-1:0] den_q;
  logic [TW-1:0] mt_q;
  logic [EW-1:0] me_q;
  logic [7:0] mp_q;
  logic [15:0] mtr_q;
  logic div_done;
  logic [chtm_pkg::NumW-1:0] quo;
  logic [EW-1:0] esat;
  logic [TW-1:0] newt;
  logic pend_q;
  logic hold_q;
  logic rel;
  logic [chtm_pkg::StatW-1:0] pst_q;
  logic [TW-1:0] ptm_q;
  logic [EW-1:0] pe_q;
  logic [7:0] ppt_q;
  logic [15:0] ptr_q;
  logic ovalid_q, olast_q;
  logic olast_out_q;
  logic [71:0] odata_q;
  logic [2:0] ouser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 16'd400;
      thr_q <= EW'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chtm_pkg::CfgWindow:    win_q <= cfg_data_i[15:0];
        chtm_pkg::CfgThreshold: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      op_q  <= in_data_i[0];
      pad_q <= in_data_i[4:1];
      t_q   <= in_data_i[24:5];
      e_q   <= in_data_i[48:25];
      pt_q  <= in_data_i[56:49];
      tr_q  <= in_data_i[72:57];
    end
  end

  assign pad_ok = 32'(pad_q) < Paddles;
  assign pidx   = PIdxW'(pad_q);
  assign n_cur  = pad_ok ? cnt_q[pidx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int i = 0; i < Paddles; i++) cnt_q[i] <= '0;
    end else begin
      if (ctrl_i.clr_idx) idx_q <= '0;
      else if (ctrl_i.inc_idx) idx_q <= idx_q + 1'b1;
      if (ctrl_i.wr_new) cnt_q[pidx] <= n_cur + 1'b1;
      else if (ctrl_i.clr_count) cnt_q[pidx] <= '0;
    end
  end

  // Address the slot given by the index; a new hit goes to slot n.
  always_comb begin
    logic [SlotW-1:0] slot;
    slot = ctrl_i.wr_new ? SlotW'(n_cur) : SlotW'(idx_q);
    addr = AddrW'(32'(pidx) * HitSlots + 32'(slot));
  end

  assign we = ctrl_i.wr_new || ctrl_i.wr_merge;
  assign wdata = ctrl_i.wr_new ? {tr_q, pt_q, e_q, t_q} : {mtr_q, mp_q, esat, newt};

  chtm_ram #(.Width(chtm_pkg::EntryW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign {rtr, rp, re, rt} = rdata;
  assign tdiff = (rt > t_q) ? {1'b0, rt} - {1'b0, t_q} : {1'b0, t_q} - {1'b0, rt};

  // Weighted time: two products accumulated in the mul1 and mul2 steps, then divide.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_slot) begin
      mt_q  <= rt;
      me_q  <= re;
      mp_q  <= (t_q < rt) ? pt_q : rp;
      mtr_q <= (t_q < rt) ? tr_q : rtr;
      den_q <= {1'b0, re} + {1'b0, e_q};
    end
    if (ctrl_i.mul1) begin
      acc_q <= chtm_pkg::NumW'(mt_q) * chtm_pkg::NumW'(me_q)
             + chtm_pkg::NumW'(den_q >> 1);
    end
    if (ctrl_i.mul2) acc_q <= acc_q + chtm_pkg::NumW'(t_q) * chtm_pkg::NumW'(e_q);
  end

  chtm_div u_div (
    .clk_i, .rst_ni, .start_i(ctrl_i.div_start), .num_i(acc_q), .den_i(den_q),
    .done_o(div_done), .quo_o(quo)
  );

  assign newt = quo[TW-1:0];
  assign esat = den_q[EW] ? '1 : den_q[EW-1:0];

  // A held readout hit waits in the result register until the scan moves on.
  assign rel = pend_q && (!hold_q || ctrl_i.flush_pending) && (!ovalid_q || m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      hold_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (ctrl_i.set_res) pend_q <= 1'b1;
      else if (rel) pend_q <= 1'b0;
      if (ctrl_i.set_res && ctrl_i.res_hold) hold_q <= 1'b1;
      else if (ctrl_i.flush_pending || ctrl_i.mark_last) hold_q <= 1'b0;
      if (rel) ovalid_q <= 1'b1;
      else if (m_tready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.set_res) begin
      pst_q   <= ctrl_i.res_status;
      olast_q <= ctrl_i.res_last;
      if (ctrl_i.res_zero) begin
        ptm_q <= '0; pe_q <= '0; ppt_q <= '0; ptr_q <= '0;
      end else if (ctrl_i.res_echo) begin
        ptm_q <= t_q; pe_q <= e_q; ppt_q <= pt_q; ptr_q <= tr_q;
      end else if (ctrl_i.res_status == chtm_pkg::StMerged) begin
        ptm_q <= newt; pe_q <= esat; ppt_q <= mp_q; ptr_q <= mtr_q;
      end else begin
        ptm_q <= rt; pe_q <= re; ppt_q <= rp; ptr_q <= rtr;
      end
    end else if (ctrl_i.mark_last) begin
      olast_q <= 1'b1;
    end
    if (rel) begin
      odata_q     <= {4'b0, ptr_q, ppt_q, pe_q, ptm_q};
      ouser_q     <= pst_q;
      olast_out_q <= olast_q;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;
  assign m_tuser_o  = ouser_q;
  assign m_tlast_o  = olast_out_q;

  assign stat_o.is_read      = (op_q == chtm_pkg::OpReadout);
  assign stat_o.ignore       = (e_q == '0) || !pad_ok;
  assign stat_o.pad_bad      = !pad_ok;
  assign stat_o.idx_end      = idx_q >= n_cur;
  assign stat_o.full         = n_cur >= CntW'(HitSlots);
  assign stat_o.hit_match    = tdiff < {1'b0, 4'b0, win_q};
  assign stat_o.over_thr     = re >= thr_q;
  assign stat_o.div_done     = div_done;
  assign stat_o.out_busy     = pend_q;
endmodule

// File: rtl/chtm_ctrl.sv
// Controller state machine for search, merge and readout sequencing.
module chtm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  chtm_pkg::stat_t stat_i,
  output chtm_pkg::ctrl_t ctrl_o
);
  chtm_pkg::state_e state_q, state_d;
  logic any_q, any_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chtm_pkg::S_IDLE;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      any_q   <= any_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    any_d      = any_q;
    ctrl_o     = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      chtm_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          ctrl_o.load_item = 1'b1;
          state_d = chtm_pkg::S_DECIDE;
        end
      end
      chtm_pkg::S_DECIDE: begin
        ctrl_o.clr_idx = 1'b1;
        any_d = 1'b0;
        if (stat_i.is_read) begin
          state_d = stat_i.pad_bad ? chtm_pkg::S_RDONE : chtm_pkg::S_RREQ;
        end else if (stat_i.ignore) begin
          if (!stat_i.out_busy) begin
            ctrl_o.set_res = 1'b1;
            ctrl_o.res_status = chtm_pkg::StIgnored;
            ctrl_o.res_zero = 1'b1;
            ctrl_o.res_last = 1'b1;
            state_d = chtm_pkg::S_IDLE;
          end
        end else begin
          state_d = chtm_pkg::S_SREQ;
        end
      end
      chtm_pkg::S_SREQ: begin
        if (stat_i.idx_end) begin
          state_d = stat_i.full ? chtm_pkg::S_EMIT : chtm_pkg::S_NEWWR;
        end else begin
          state_d = chtm_pkg::S_SCHK;
        end
      end
      chtm_pkg::S_SCHK: begin
        if (stat_i.hit_match) begin
          ctrl_o.rd_slot = 1'b1;
          state_d = chtm_pkg::S_MUL1;
        end else begin
          ctrl_o.inc_idx = 1'b1;
          state_d = chtm_pkg::S_SREQ;
        end
      end
      chtm_pkg::S_MUL1: begin
        ctrl_o.mul1 = 1'b1;
        state_d = chtm_pkg::S_MUL2;
      end
      chtm_pkg::S_MUL2: begin
        ctrl_o.mul2 = 1'b1;
        state_d = chtm_pkg::S_DIV;
      end
      chtm_pkg::S_DIV: begin
        ctrl_o.div_start = 1'b1;
        state_d = chtm_pkg::S_MWR;
      end
      chtm_pkg::S_MWR: begin
        if (stat_i.div_done && !stat_i.out_busy) begin
          ctrl_o.wr_merge = 1'b1;
          ctrl_o.set_res = 1'b1;
          ctrl_o.res_status = chtm_pkg::StMerged;
          ctrl_o.res_last = 1'b1;
          state_d = chtm_pkg::S_IDLE;
        end
      end
      chtm_pkg::S_NEWWR: begin
        if (!stat_i.out_busy) begin
          ctrl_o.set_res = 1'b1;
          ctrl_o.res_status = chtm_pkg::StNew;
          ctrl_o.res_echo = 1'b1;
          ctrl_o.res_last = 1'b1;
          ctrl_o.wr_new = 1'b1;
          state_d = chtm_pkg::S_IDLE;
        end
      end
      chtm_pkg::S_EMIT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.set_res = 1'b1;
          ctrl_o.res_status = chtm_pkg::StFull;
          ctrl_o.res_echo = 1'b1;
          ctrl_o.res_last = 1'b1;
          state_d = chtm_pkg::S_IDLE;
        end
      end
      chtm_pkg::S_RREQ: begin
        state_d = stat_i.idx_end ? chtm_pkg::S_RDONE : chtm_pkg::S_RCHK;
      end
      chtm_pkg::S_RCHK: begin
        if (stat_i.over_thr) begin
          state_d = chtm_pkg::S_REMIT;
        end else begin
          ctrl_o.inc_idx = 1'b1;
          state_d = chtm_pkg::S_RREQ;
        end
      end
      chtm_pkg::S_REMIT: begin
        // Each hit is held in the result register with last low until the
        // scan finds the next qualifying hit, which releases it, or ends,
        // which marks it as the final one.
        ctrl_o.flush_pending = 1'b1;
        if (!stat_i.out_busy) begin
          ctrl_o.set_res = 1'b1;
          ctrl_o.res_status = chtm_pkg::StReadHit;
          ctrl_o.res_last = 1'b0;
          ctrl_o.res_hold = 1'b1;
          ctrl_o.inc_idx = 1'b1;
          any_d = 1'b1;
          state_d = chtm_pkg::S_RREQ;
        end
      end
      chtm_pkg::S_RDONE: begin
        if (any_q) begin
          ctrl_o.clr_count = 1'b1;
          ctrl_o.mark_last = 1'b1;
          state_d = chtm_pkg::S_IDLE;
        end else if (!stat_i.out_busy) begin
          ctrl_o.clr_count = !stat_i.pad_bad;
          ctrl_o.set_res = 1'b1;
          ctrl_o.res_status = chtm_pkg::StReadNone;
          ctrl_o.res_zero = 1'b1;
          ctrl_o.res_last = 1'b1;
          state_d = chtm_pkg::S_IDLE;
        end
      end
      default: state_d = chtm_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_new |-> !ctrl_o.wr_merge) else $error("two table writes at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.set_res |-> !stat_i.out_busy) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_item |=> state_q == chtm_pkg::S_DECIDE) else $error("item lost");
endmodule

// File: rtl/channel_hit_time_merger.sv
// Channel hit time merger: per-paddle hit table with energy-weighted time merge.
// A deposit scans the paddle's stored hits one slot at a time through a single
// RAM port, and a merge then computes the weighted time in a serial divider at
// one quotient bit per cycle. A readout scans the stored hits likewise, emits
// each qualifying hit, and is held up while the result output is stalled. No
// item is accepted while another is in work. Entries of the hit tables are not
// cleared at reset; the per-paddle counts are, so no clearing pass is needed.
module channel_hit_time_merger #(
  parameter int unsigned HIT_SLOTS = 32,
  parameter int unsigned PADDLES   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // paddle, hit_time, deposit_energy, particle_type, track_id
  input  logic [71:0] s_tdata,
  // op
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_time, out_energy, out_particle, out_track, zero pad
  output logic [71:0] m_tdata,
  // status
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  chtm_pkg::ctrl_t ctrl;
  chtm_pkg::stat_t stat;

  chtm_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  chtm_datapath #(.HitSlots(HIT_SLOTS), .Paddles(PADDLES)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .in_data_i({s_tdata, s_tuser}),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata),
    .m_tuser_o(m_tuser), .m_tlast_o(m_tlast)
  );
endmodule

// File: bench/chtm_checker.sv
// Checker for the channel hit time merger: predicts results and compares them.
`timescale 1ns / 100ps

module chtm_checker #(
  parameter int unsigned HIT_SLOTS = 32,
  parameter int unsigned PADDLES   = 16
) (
  input  logic        clk_i,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  typedef struct packed {
    logic [chtm_pkg::StatW-1:0]   status;
    logic [chtm_pkg::TimeW-1:0]   t;
    logic [chtm_pkg::EnergyW-1:0] e;
    logic [chtm_pkg::PartW-1:0]   p;
    logic [chtm_pkg::TrackW-1:0]  tr;
    logic                         last;
  } hit_result_t;

  hit_result_t expected_hits[$];

  logic [15:0]                  window;
  logic [chtm_pkg::EnergyW-1:0] threshold;
  logic [chtm_pkg::TimeW-1:0]   tab_t[PADDLES][HIT_SLOTS];
  logic [chtm_pkg::EnergyW-1:0] tab_e[PADDLES][HIT_SLOTS];
  logic [chtm_pkg::PartW-1:0]   tab_p[PADDLES][HIT_SLOTS];
  logic [chtm_pkg::TrackW-1:0]  tab_tr[PADDLES][HIT_SLOTS];
  int                           hit_count[PADDLES];

  initial begin
    window = 16'd400;
    threshold = 24'd100;
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
    for (int i = 0; i < PADDLES; i++) hit_count[i] = 0;
  end

  function automatic hit_result_t mk(logic [2:0] st, logic [19:0] t,
                                     logic [23:0] e, logic [7:0] p,
                                     logic [15:0] tr, logic last);
    hit_result_t r;
    r.status = st; r.t = t; r.e = e; r.p = p; r.tr = tr; r.last = last;
    return r;
  endfunction

  task automatic predict_item(input logic op, input logic [71:0] d);
    int          pad, n, i, k;
    logic [19:0] t;
    logic [23:0] e;
    logic [7:0]  p;
    logic [15:0] tr;
    logic [19:0] s, tdist;
    logic [63:0] num, den;
    pad = int'(d[3:0]); t = d[23:4]; e = d[47:24]; p = d[55:48]; tr = d[71:56];
    if (op == chtm_pkg::OpDeposit) begin
      if (e == 0 || pad >= PADDLES) begin
        expected_hits.push_back(mk(chtm_pkg::StIgnored, 20'd0, 24'd0, 8'd0, 16'd0, 1'b1));
        return;
      end
      n = hit_count[pad];
      for (i = 0; i < n; i++) begin
        s = tab_t[pad][i];
        tdist = (s > t) ? s - t : t - s;
        if (tdist < window) break;
      end
      if (i < n) begin
        den = 64'(tab_e[pad][i]) + 64'(e);
        num = 64'(tab_t[pad][i]) * 64'(tab_e[pad][i]) + 64'(t) * 64'(e);
        if (t < tab_t[pad][i]) begin
          tab_p[pad][i] = p;
          tab_tr[pad][i] = tr;
        end
        tab_t[pad][i] = 20'((num + den / 2) / den);
        tab_e[pad][i] = (den > 64'hFFFFFF) ? 24'hFFFFFF : den[23:0];
        expected_hits.push_back(mk(chtm_pkg::StMerged, tab_t[pad][i], tab_e[pad][i],
                                   tab_p[pad][i], tab_tr[pad][i], 1'b1));
      end else if (n < HIT_SLOTS) begin
        tab_t[pad][n] = t; tab_e[pad][n] = e; tab_p[pad][n] = p; tab_tr[pad][n] = tr;
        hit_count[pad] = n + 1;
        expected_hits.push_back(mk(chtm_pkg::StNew, t, e, p, tr, 1'b1));
      end else begin
        expected_hits.push_back(mk(chtm_pkg::StFull, t, e, p, tr, 1'b1));
      end
    end else begin
      if (pad >= PADDLES) begin
        expected_hits.push_back(mk(chtm_pkg::StReadNone, 20'd0, 24'd0, 8'd0, 16'd0, 1'b1));
        return;
      end
      k = 0;
      for (i = 0; i < hit_count[pad]; i++) begin
        if (tab_e[pad][i] >= threshold) begin
          expected_hits.push_back(mk(chtm_pkg::StReadHit, tab_t[pad][i], tab_e[pad][i],
                                     tab_p[pad][i], tab_tr[pad][i], 1'b0));
          k++;
        end
      end
      hit_count[pad] = 0;
      if (k == 0) begin
        expected_hits.push_back(mk(chtm_pkg::StReadNone, 20'd0, 24'd0, 8'd0, 16'd0, 1'b1));
      end else begin
        expected_hits[$].last = 1'b1;
      end
    end
  endtask

  task automatic check_result();
    hit_result_t got, exp_r;
    got = mk(m_tuser, m_tdata[19:0], m_tdata[43:20], m_tdata[51:44],
             m_tdata[67:52], m_tlast);
    result_count++;
    if (expected_hits.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    exp_r = expected_hits.pop_front();
    if (got.status != exp_r.status || got.t != exp_r.t || got.e != exp_r.e ||
        got.p != exp_r.p || got.tr != exp_r.tr || got.last != exp_r.last) begin
      $display("%0t: mismatch, expected st=%0d t=%0d e=%0d p=%0d tr=%0d last=%0b",
               $time, exp_r.status, exp_r.t, exp_r.e, exp_r.p, exp_r.tr, exp_r.last);
      $display("%0t:           actual st=%0d t=%0d e=%0d p=%0d tr=%0d last=%0b",
               $time, got.status, got.t, got.e, got.p, got.tr, got.last);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (cfg_we_i) begin
      if (cfg_idx_i == chtm_pkg::CfgWindow) window = cfg_data_i[15:0];
      else threshold = cfg_data_i;
    end
    if (m_tvalid && m_tready) check_result();
    if (s_tvalid && s_tready) predict_item(s_tuser[0], s_tdata);
    pending_count = expected_hits.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the channel hit time merger testbench: stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = chtm_pkg::CfgWindow;
  logic [23:0] cfg_data_i = '0;

  int fail_count, pending_count, result_count;
  int sent_items = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  channel_hit_time_merger i_dut (.*);

  chtm_checker i_checker (.*);

  task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Leaves tvalid high after the transfer; drain() drops it, and the next call drops it only before a gap.
  task automatic send_item(input logic op, input logic [3:0] pad, input logic [19:0] t,
                           input logic [23:0] e, input logic [7:0] p,
                           input logic [15:0] tr, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {tr, p, e, t, pad};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic random_phase(input int count, input int npads, input int spread);
    logic [19:0] base_t;
    int r;
    base_t = 20'($urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12)
        send_item(chtm_pkg::OpReadout, 4'($urandom_range(0, npads - 1)), 20'($urandom),
                  24'($urandom), 8'($urandom), 16'($urandom), 1);
      else if (r < 17)
        send_item(chtm_pkg::OpDeposit, 4'($urandom), 20'($urandom), 24'd0,
                  8'($urandom), 16'($urandom), 1);
      else if (r < 25)
        send_item(chtm_pkg::OpDeposit, 4'($urandom), 20'($urandom), 24'($urandom),
                  8'($urandom), 16'($urandom), 1);
      else
        send_item(chtm_pkg::OpDeposit, 4'($urandom_range(0, npads - 1)),
                  base_t + 20'($urandom_range(0, spread)),
                  ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 600)),
                  8'($urandom), 16'($urandom), 1);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, merge, earlier merge, saturation, readouts.
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'd1000, 24'd200, 8'd0, 16'd0, 1);
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'd1100, 24'd300, 8'hFF, 16'hFFFF, 1);
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'd900, 24'd1, 8'hA5, 16'h5A5A, 1);
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'd2000, 24'hFFFFFF, 8'd7, 16'd7, 1);
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'd2001, 24'hFFFFFF, 8'd8, 16'd8, 1);
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'hFFFFF, 24'd50, 8'd9, 16'd9, 1);
    send_item(chtm_pkg::OpDeposit, 4'd0, 20'd0, 24'd0, 8'hFF, 16'hFFFF, 1);
    send_item(chtm_pkg::OpDeposit, 4'd15, 20'd0, 24'd1, 8'd1, 16'd1, 1);
    send_item(chtm_pkg::OpReadout, 4'd0, 20'hFFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1);
    send_item(chtm_pkg::OpReadout, 4'd0, 20'd0, 24'd0, 8'd0, 16'd0, 1);
    send_item(chtm_pkg::OpReadout, 4'd15, 20'd0, 24'd0, 8'd0, 16'd0, 1);
    drain();

    // Window zero: nothing merges, so paddle 3 fills and then overflows.
    write_reg(chtm_pkg::CfgWindow, 24'd0);
    write_reg(chtm_pkg::CfgThreshold, 24'd0);
    for (int i = 0; i < 34; i++)
      send_item(chtm_pkg::OpDeposit, 4'd3, 20'd5000, 24'(i + 1), 8'(i), 16'(i), 0);
    send_item(chtm_pkg::OpReadout, 4'd3, 20'd0, 24'd0, 8'd0, 16'd0, 0);
    drain();

    write_reg(chtm_pkg::CfgWindow, 24'hFFFF);
    write_reg(chtm_pkg::CfgThreshold, 24'hFFFFFF);
    random_phase(20, 4, 200000);
    for (int i = 0; i < 4; i++)
      send_item(chtm_pkg::OpReadout, 4'(i), 20'd0, 24'd0, 8'd0, 16'd0, 1);
    drain();

    write_reg(chtm_pkg::CfgWindow, 24'd400);
    write_reg(chtm_pkg::CfgThreshold, 24'd300);
    long_hold = 1'b1;
    random_phase(50, 3, 3000);
    drain();

    write_reg(chtm_pkg::CfgWindow, 24'd40);
    write_reg(chtm_pkg::CfgThreshold, 24'd1);
    random_phase(50, 2, 2000);
    for (int i = 0; i < 2; i++)
      send_item(chtm_pkg::OpReadout, 4'(i), 20'd0, 24'd0, 8'd0, 16'd0, 1);
    drain();
    stim_done = 1'b1;

    $display("Sent %0d items and checked %0d results across five register settings,",
             sent_items, result_count);
    $display("covering merges, saturation, a full table, readouts and stalls.");
    if (fail_count == 0) begin
      $display("channel_hit_time_merger test passed");
    end else begin
      $display("channel_hit_time_merger test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("channel_hit_time_merger test failed");
    $finish;
  end

endmodule
